/* sv/itoa_pkg.sv */
// Shared types, constants and helper functions of the radix ASCII converter.
`default_nettype none

package itoa_pkg;

  // Width of the converted number and of the input value field.
  localparam int VALUE_BITS   = 16;
  localparam int VALUE_W      = 16;
  localparam int RADIX_W      = 6;
  localparam int CHAR_W       = 7;

  // Input and output stream widths, padded to whole bytes.
  localparam int S_TDATA_W    = ((VALUE_W + RADIX_W + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((CHAR_W + 7) / 8) * 8;

  // Divider: quotient bits resolved per cycle and cycles per digit.
  localparam int DIV_STEPS    = 8;
  localparam int DIV_CYCLES   = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_BITS     = DIV_CYCLES * DIV_STEPS;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES + 1);

  // Digit buffer index; a conversion never yields more than VALUE_BITS digits.
  localparam int DIG_W        = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Radix bounds and character constants.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_NINE = CHAR_W'(57);
  localparam logic [CHAR_W-1:0]  ALPHA_GAP = CHAR_W'(7);

  // One classified request waiting for conversion.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  // Clamp a radix into the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d) + CHAR_ZERO;
    if (c > CHAR_NINE) c = c + ALPHA_GAP;
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/itoa_front.sv */
// Front end: accepts requests, clamps the radix and queues them for the back end.
`default_nettype none

module itoa_front import itoa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic [VALUE_W-1:0]   s_value_i,
  input  wire logic [RADIX_W-1:0]   s_radix_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output item_t                     q_item_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;
  item_t             item_in;

  // Classify the incoming request.
  always_comb begin
    item_in.value = VALUE_BITS'(s_value_i);
    item_in.radix = clamp_radix(s_radix_i);
  end

  assign s_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/itoa_div.sv */
// Iterative divider: resolves several quotient bits per cycle by a small radix.
`default_nettype none

module itoa_div import itoa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic [VALUE_BITS-1:0]      quotient_o,
  output logic [RADIX_W-1:0]         remainder_o
);

  logic [PAD_BITS-1:0]  quo_q, quo_d;
  logic [RADIX_W-1:0]   rem_q, rem_d;
  logic [RADIX_W-1:0]   div_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [RADIX_W:0]     trial;

  // Restoring division steps for one cycle; the remainder stays below the divisor.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, quo_d[PAD_BITS-1]};
      quo_d = {quo_d[PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[RADIX_W-1:0];
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= PAD_BITS'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Cycle count and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_CYCLES - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* sv/itoa_back.sv */
// Back end: produces digits with the divider, buffers them and sends them out most significant digit first.
`default_nettype none

module itoa_back import itoa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  wire item_t             q_item_i,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output logic [CHAR_W-1:0]      m_char_o,
  output logic                   m_last_o
);

  back_state_e           state_q, state_d;
  logic [DIG_W-1:0]      idx_q;
  logic [RADIX_W-1:0]    radix_q;
  logic [CHAR_W-1:0]     buf_q [VALUE_BITS];
  logic                  m_valid_q, m_last_q;
  logic [CHAR_W-1:0]     m_char_q;

  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] div_dividend, div_quo;
  logic [RADIX_W-1:0]    div_divisor, div_rem;
  logic                  take, more, finish, out_free, load;

  itoa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_DIV;
      BK_DIV:  if (div_done && div_quo == '0) state_d = BK_EMIT;
      BK_EMIT: if (out_free && idx_q == '0) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    take         = 1'b0;
    more         = 1'b0;
    finish       = 1'b0;
    load         = 1'b0;
    div_dividend = div_quo;
    div_divisor  = radix_q;
    case (state_q)
      BK_IDLE: begin
        take         = q_valid_i;
        div_dividend = q_item_i.value;
        div_divisor  = q_item_i.radix;
      end
      BK_DIV: begin
        more   = div_done && (div_quo != '0);
        finish = div_done && (div_quo == '0);
      end
      BK_EMIT: begin
        load = out_free;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  assign out_free  = !m_valid_q || m_ready_i;
  assign div_start = take || more;
  assign q_ready_o = (state_q == BK_IDLE);

  // Digit buffer, filled least significant digit first.
  always_ff @(posedge clk_i) begin
    if (more || finish) begin
      buf_q[idx_q] <= to_char(div_rem);
    end
    if (take) begin
      radix_q <= q_item_i.radix;
    end
    if (load) begin
      m_char_q <= buf_q[idx_q];
      m_last_q <= (idx_q == '0);
    end
  end

  // State, digit index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        idx_q <= '0;
      end else if (more) begin
        idx_q <= idx_q + 1'b1;
      end else if (load && idx_q != '0) begin
        idx_q <= idx_q - 1'b1;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_char_o  = m_char_q;
  assign m_last_o  = m_last_q;

endmodule

`default_nettype wire

/* sv/integer_to_radix_ascii.sv */
// Top level of the unsigned integer to radix ASCII digit converter.
//
//  Channel  Direction  Payload                               Frame marker
//  s_axis   in         tdata: value[15:0], radix[21:16]      none
//  m_axis   out        tdata: digit_char[6:0]                tlast on final digit
//
// A conversion yields n digits (1 to 16). The back end produces them one by one in the
// shared divider, which resolves eight quotient bits a cycle, then sends the buffered
// characters out.
// A two-entry queue lets requests be taken while the back end is busy or stalled.
// Reset clears only control state; nothing is kept between requests.
`default_nettype none

module integer_to_radix_ascii import itoa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // value[15:0], radix[21:16]
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,  // digit_char[6:0]
  output logic                      m_axis_tlast_o
);

  logic              q_valid, q_ready;
  item_t             q_item;
  logic [CHAR_W-1:0] m_char;

  // Request intake and queue.
  itoa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_value_i (s_axis_tdata_i[VALUE_W-1:0]),
    .s_radix_i (s_axis_tdata_i[VALUE_W+RADIX_W-1:VALUE_W]),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  // Digit generation and output.
  itoa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (m_char),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = M_TDATA_W'(m_char);

endmodule

`default_nettype wire

/* dv/itoa_checker.sv */
// Checker module that predicts the digit stream of the radix converter and compares it.
`default_nettype none

module itoa_checker import itoa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  input  wire logic                 s_tready_i,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,  // value[15:0], radix[21:16]
  input  wire logic                 m_tvalid_i,
  input  wire logic                 m_tready_i,
  input  wire logic [M_TDATA_W-1:0] m_tdata_i,  // digit_char[6:0]
  input  wire logic                 m_tlast_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  // One predicted output character and its end-of-conversion marker.
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_t;

  digit_t      pending_digits[$];
  int unsigned digits_seen;

  // Work out the digits of one request, most significant first, and queue them.
  function automatic void queue_digits(input logic [VALUE_W-1:0] value,
                                       input logic [RADIX_W-1:0] radix);
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] base;
    logic [CHAR_W-1:0]  lsd_first [VALUE_BITS];
    logic [CHAR_W-1:0]  ch;
    digit_t             d;
    int                 count;
    num   = value;
    base  = VALUE_W'(radix);
    count = 0;
    // Out-of-range radices are pulled back to the nearest supported bound.
    if (base < VALUE_W'(RADIX_MIN)) base = VALUE_W'(RADIX_MIN);
    if (base > VALUE_W'(RADIX_MAX)) base = VALUE_W'(RADIX_MAX);
    // Digits come out least significant first; zero still gives one digit.
    do begin
      ch = CHAR_W'(num % base) + CHAR_ZERO;
      if (ch > CHAR_NINE) ch = ch + ALPHA_GAP;
      if (count < VALUE_BITS) begin
        lsd_first[count] = ch;
        count++;
      end
      num = num / base;
    end while (num != '0);
    for (int k = count - 1; k >= 0; k--) begin
      d.digit_char = lsd_first[k];
      d.last       = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // Count a failure and describe the first few of them.
  task automatic note_failure(input string what, input digit_t want, input digit_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("itoa check: %s at digit %0d: expected char 0x%02h last %0b, got char 0x%02h last %0b",
               what, digits_seen, want.digit_char, want.last, got.digit_char, got.last);
  endtask

  // Compare each accepted digit with the oldest prediction, then take new requests.
  always @(posedge clk_i or negedge rst_ni) begin
    digit_t got;
    digit_t want;
    if (!rst_ni) begin
      pending_digits.delete();
      digits_seen  = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.digit_char = m_tdata_i[CHAR_W-1:0];
        got.last       = m_tlast_i;
        if (pending_digits.size() == 0) begin
          want = '0;
          note_failure("unexpected digit", want, got);
        end else begin
          want = pending_digits.pop_front();
          if (got.digit_char !== want.digit_char || got.last !== want.last)
            note_failure("wrong digit", want, got);
        end
        digits_seen++;
      end
      if (s_tvalid_i && s_tready_i)
        queue_digits(s_tdata_i[VALUE_W-1:0], s_tdata_i[VALUE_W +: RADIX_W]);
      pending_o = pending_digits.size();
    end
  end

endmodule

`default_nettype wire

/* dv/tb_integer_to_radix_ascii.sv */
// Testbench top that drives requests into the radix converter and reports the verdict.
`default_nettype none

module tb_integer_to_radix_ascii;
  import itoa_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  int unsigned          fail_count;
  int unsigned          pending;
  bit                   no_idle;

  integer_to_radix_ascii dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  itoa_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #5_000_000;
    $display("integer_to_radix_ascii: mismatch");
    $finish;
  end

  // Idle cycles before the next request or digit; none during the back-to-back stretches.
  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(12, 0);
  endfunction

  // Offer one conversion request and hold it until the block takes it.
  task automatic send_request(input logic [VALUE_W-1:0] value,
                              input logic [RADIX_W-1:0] radix);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = S_TDATA_W'({radix, value});
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: stall a random number of cycles before each digit.
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus, drain and verdict.
  initial begin
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    no_idle  = 1'b0;
    rst_n    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cases: zero, field extremes, letter digits and clamped radices.
    send_request(16'd0,     6'd10);
    send_request(16'hFFFF,  6'd2);
    send_request(16'hFFFF,  6'd36);
    send_request(16'hFFFF,  6'd16);
    send_request(16'h8000,  6'd2);
    send_request(16'd0,     6'd0);
    send_request(16'd5,     6'd1);
    send_request(16'd12345, 6'd63);
    send_request(16'd0,     6'd63);
    send_request(16'd100,   6'd37);
    send_request(16'd35,    6'd36);
    send_request(16'd10,    6'd16);
    send_request(16'd9,     6'd10);
    send_request(16'd255,   6'd16);
    send_request(16'd1,     6'd2);
    send_request(16'd26,    6'd3);
    send_request(16'd4095,  6'd8);
    send_request(16'd1295,  6'd36);
    send_request(16'd34,    6'd35);
    send_request(16'h5555,  6'd7);

    // Random requests, with a stretch of back-to-back traffic every so often.
    for (int i = 0; i < 480; i++) begin
      no_idle = ((i / 40) % 4 == 3);
      case ($urandom_range(3, 0))
        0:       value = VALUE_W'($urandom_range(40, 0));
        1:       value = 16'hFFFF - VALUE_W'($urandom_range(40, 0));
        default: value = VALUE_W'($urandom);
      endcase
      if ($urandom_range(9, 0) == 0)
        radix = RADIX_W'($urandom_range(63, 0));
      else
        radix = RADIX_W'($urandom_range(36, 2));
      send_request(value, radix);
    end
    s_tvalid = 1'b0;
    no_idle  = 1'b0;

    // Let every predicted digit arrive, then watch for strays.
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("integer_to_radix_ascii: match");
    else
      $display("integer_to_radix_ascii: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
